// ----- rtl/pixel_key_sorter_macros.svh -----
// Assertion macros for the pixel key sorter.
`ifndef PIXEL_KEY_SORTER_MACROS_SVH
`define PIXEL_KEY_SORTER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define PKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pks_pkg.sv -----
// Shared types and constants for the pixel key sorter.
package pks_pkg;

    localparam int CAPACITY  = 256;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 24;
    localparam int OUT_CNT_W = 9;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TAKE   = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic ins;
        logic take;
        t_key key;
    } t_ctl;

endpackage

// ----- rtl/pks_cell.sv -----
// One cell of the sorted chain: holds a key, inserts, shifts away from or toward cell 0.
module pks_cell
    import pks_pkg::*;
(
    input  logic i_clk,
    input  t_ctl i_ctl,
    input  logic i_occ,
    input  t_key i_left_key,
    input  logic i_left_gt,
    input  t_key i_right_key,
    output t_key o_key,
    output logic o_gt
);

    t_key r_key;
    t_key n_key;

    // empty cells act as +infinity
    assign o_gt  = !i_occ || (r_key > i_ctl.key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && o_gt) begin
            n_key = i_left_gt ? i_left_key : i_ctl.key;
        end else if (i_ctl.take) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ----- rtl/pixel_key_sorter.sv -----
// Top level of the pixel key sorter: cell chain, fill count and result register.
`include "pixel_key_sorter_macros.svh"

// Sorted store of up to 256 pixels, ordered by blue, then green, then red.
// For every item, all cells compare the incoming key against their own
// contents in parallel and shift one place toward or away from cell 0,
// so a new item is accepted each cycle unless the output register stalls.
// The result of an item sits in the output register the cycle after its
// transfer; input is accepted whenever that register is empty or being
// taken in the same cycle. No clearing pass is needed after reset.
module pixel_key_sorter
    import pks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // in_blue[7:0], in_green[15:8], in_red[23:16]
    input  logic        i_s_tuser,  // kind[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // out_blue[7:0], out_green[15:8], out_red[23:16],
                                    // stored_count[32:24], zero[39:33]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_m_valid;
    logic             n_m_valid;
    logic [39:0]      r_m_data;
    logic [1:0]       r_m_user;
    logic [1:0]       n_status;
    logic             w_acc;
    logic             w_full;
    logic             w_empty;
    t_ctl             w_ctl;
    t_key             w_in_key;
    t_key             w_taken;
    t_key             w_key [CAPACITY];
    logic             w_gt  [CAPACITY];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_in_key   = {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};

    assign w_ctl.ins  = w_acc && (i_s_tuser == KIND_INSERT) && !w_full;
    assign w_ctl.take = w_acc && (i_s_tuser == KIND_TAKE) && !w_empty;
    assign w_ctl.key  = w_in_key;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_key w_left;
            logic w_left_gt;
            t_key w_right;
            if (g == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_key[g-1];
                assign w_left_gt = w_gt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_key[g];
            end else begin : g_inner
                assign w_right = w_key[g+1];
            end
            pks_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (CNT_W'(g) < r_count),
                .i_left_key  (w_left),
                .i_left_gt   (w_left_gt),
                .i_right_key (w_right),
                .o_key       (w_key[g]),
                .o_gt        (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        w_taken  = '0;
        if (i_s_tuser == KIND_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                w_taken = w_key[0];
            end
        end
        n_m_valid = r_m_valid && !i_m_tready;
        if (w_acc) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (w_acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_m_data <= {7'd0, OUT_CNT_W'(n_count), w_taken[7:0], w_taken[15:8],
                         w_taken[23:16]};
            r_m_user <= n_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    `PKS_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count over capacity")
    `PKS_ASSERT_NEXT(a_full_drop, w_acc && (i_s_tuser == KIND_INSERT) && w_full,
        (o_m_tuser == ST_FULL) && (r_count == $past(r_count)), "full insert not dropped")
    `PKS_ASSERT_NEXT(a_take_dec, w_acc && (i_s_tuser == KIND_TAKE) && !w_empty,
        (r_count == $past(r_count) - 1'b1) && (o_m_tuser == ST_DONE), "take count wrong")
    `PKS_ASSERT_NEXT(a_empty_take, w_acc && (i_s_tuser == KIND_TAKE) && w_empty,
        (o_m_tuser == ST_EMPTY) && (o_m_tdata[23:0] == 24'd0), "empty take result wrong")

endmodule
